// ----- design/powm_pkg.sv -----
// Shared types and constants for the pulse oximetry window monitor.
`default_nettype none
package powm_pkg;
  localparam int WINDOW_DEF = 100;
  localparam int SAMPLE_BITS_DEF = 18;

  typedef enum logic [2:0] {
    CFG_SPO2_FLOOR = 3'd0,
    CFG_HR_MIN = 3'd1,
    CFG_HR_MAX = 3'd2,
    CFG_FINGER_LEVEL = 3'd3,
    CFG_MIN_PEAK_GAP = 3'd4,
    CFG_BPM_PER_PEAK = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM,
    ST_MEAN,
    ST_DIV,
    ST_PEAK_RD,
    ST_PEAK,
    ST_HR,
    ST_DONE,
    ST_SHIFT
  } state_t;
endpackage
`default_nettype wire

// ----- design/powm_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module powm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/powm_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module powm_divider #(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic      [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem;
  logic [W-1:0] dsr;
  logic [W-1:0] num;
  logic [CW-1:0] cnt;
  logic [W:0] trial;

  assign trial = {rem, num[W-1]} - {1'b0, dsr};

  // On start, load the operands; while busy, shift one dividend bit into the remainder and try the subtraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(W);
      rem <= '0;
      num <= dividend;
      dsr <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (!trial[W]) rem <= trial[W-1:0];
      else rem <= {rem[W-2:0], num[W-1]};
      num <= {num[W-2:0], 1'b0};
      quotient <= {quotient[W-2:0], ~trial[W]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- design/pulse_oximetry_window_monitor.sv -----
// A push holds in_ready low for one cycle (pair written at the oldest slot); an
// evaluate sums both windows, forms the mean from MCH reciprocal chunks, runs the
// DW-bit divider and scans the infrared window for peaks before raising out_valid.
// One request at a time; a finished result may wait in the output registers while
// the next request runs, and an evaluate holds before its write-back until it is taken.
// Synchronous reset restores the control and limit registers and clears the windows in a clearing pass.
`default_nettype none
module pulse_oximetry_window_monitor #(
  parameter int WINDOW = powm_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = powm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [17:0] red_sample,
  input  wire logic [17:0] ir_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [6:0]  spo2_value,
  output logic      [13:0] heart_rate,
  output logic      [17:0] average_ir,
  output logic             finger_present,
  output logic             alarm,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = $clog2(WINDOW);
  localparam int SB = SAMPLE_BITS;
  localparam int SUMW = SB + $clog2(WINDOW + 1);
  localparam int DW = SUMW + 5;
  localparam int PCW = $clog2(WINDOW + 1);
  localparam int GW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int FW = (SUMW > 18) ? SUMW : 18;
  // Mean by reciprocal multiplication, 16 bits of the reciprocal per cycle.
  localparam int SH = SUMW + $clog2(WINDOW);
  localparam int MW = SUMW + 1;
  localparam int MCH = (MW + 15) / 16;
  localparam int KW = (MCH > 1) ? $clog2(MCH) : 1;
  localparam int PW = SUMW + 16 * MCH;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [16*MCH-1:0] RECIP_V = (16*MCH)'(RECIP);

  // Configuration registers.
  logic [6:0] spo2_floor;
  logic [13:0] hr_min, hr_max;
  logic [17:0] finger_level;
  logic [7:0] min_peak_gap, bpm_per_peak;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spo2_floor <= 7'd90;
      hr_min <= 14'd40;
      hr_max <= 14'd130;
      finger_level <= 18'd10000;
      min_peak_gap <= 8'd25;
      bpm_per_peak <= 8'd60;
    end else if (cfg_valid) begin
      case (cfg_index)
        powm_pkg::CFG_SPO2_FLOOR: spo2_floor <= cfg_data[6:0];
        powm_pkg::CFG_HR_MIN: hr_min <= cfg_data[13:0];
        powm_pkg::CFG_HR_MAX: hr_max <= cfg_data[13:0];
        powm_pkg::CFG_FINGER_LEVEL: finger_level <= cfg_data[17:0];
        powm_pkg::CFG_MIN_PEAK_GAP: min_peak_gap <= cfg_data[7:0];
        powm_pkg::CFG_BPM_PER_PEAK: bpm_per_peak <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Windows are circular buffers; head is the oldest entry.
  powm_pkg::state_t state, state_next;
  logic [AW-1:0] head, raddr, waddr, addr_idx;
  logic [AW:0] idx;
  logic we, clearing;
  logic [SB-1:0] red_q, ir_q, red_w, ir_w, ir_in, red_in;
  logic [SUMW-1:0] red_sum, ir_sum, mean;
  logic [PCW-1:0] peaks;
  logic [AW:0] last;
  logic have_last;
  logic [SB-1:0] prev2, prev1;
  logic [SB-1:0] ir_hold, red_hold;
  logic div_start, div_busy, div_phase;
  logic [DW-1:0] div_num, div_den, div_q;
  logic [6:0] spo2_r;
  logic [KW-1:0] mul_k;
  logic [15:0] mul_chunk;
  logic [SUMW+15:0] mul_part;
  logic [PW-1:0] acc;
  logic hr_go;

  assign ir_in = SB'(ir_sample);
  assign red_in = SB'(red_sample);

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [AW:0] o);
    logic [AW+1:0] s;
    s = {2'b0, h} + {1'b0, o};
    if (s >= (AW+2)'(WINDOW)) s = s - (AW+2)'(WINDOW);
    return s[AW-1:0];
  endfunction

  assign addr_idx = wrap(head, idx);
  assign raddr = addr_idx;

  powm_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_red (
    .clk, .we, .waddr, .wdata(red_w), .raddr, .rdata(red_q));
  powm_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_ir (
    .clk, .we, .waddr, .wdata(ir_w), .raddr, .rdata(ir_q));

  powm_divider #(.W(DW)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_num), .divisor(div_den),
    .busy(div_busy), .quotient(div_q));

  // Write port: clearing pass or push of a new pair at the oldest slot.
  always_comb begin
    we = 1'b0;
    waddr = head;
    red_w = red_hold;
    ir_w = ir_hold;
    if (clearing) begin
      we = 1'b1;
      waddr = idx[AW-1:0];
      red_w = '0;
      ir_w = '0;
    end else if (state == powm_pkg::ST_SHIFT) begin
      we = 1'b1;
    end
  end

  assign in_ready = (state == powm_pkg::ST_IDLE) && !clearing;

  // The result registers are free once the pending result is taken.
  assign hr_go = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= powm_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic [AW:0] gap_d;
  logic peak_hit;
  assign gap_d = idx - 2'd2 - last;
  assign peak_hit = ({{(SUMW-SB){1'b0}}, prev1} > mean) && (prev1 > prev2) && (prev1 > ir_q);

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      powm_pkg::ST_IDLE:
        if (in_valid && in_ready) state_next = req_type ? powm_pkg::ST_SUM_RD
                                                        : powm_pkg::ST_SHIFT;
      powm_pkg::ST_SHIFT: state_next = powm_pkg::ST_IDLE;
      powm_pkg::ST_SUM_RD: state_next = powm_pkg::ST_SUM;
      powm_pkg::ST_SUM:
        if (idx == (AW+1)'(WINDOW)) state_next = powm_pkg::ST_MEAN;
      powm_pkg::ST_MEAN:
        if (mul_k == '0) begin
          state_next = powm_pkg::ST_DIV;
          div_start = 1'b1;
        end
      powm_pkg::ST_DIV:
        if (!div_busy && div_phase) state_next = powm_pkg::ST_PEAK_RD;
      powm_pkg::ST_PEAK_RD: state_next = powm_pkg::ST_PEAK;
      powm_pkg::ST_PEAK:
        if (idx == (AW+1)'(WINDOW)) state_next = powm_pkg::ST_HR;
      powm_pkg::ST_HR:
        if (hr_go) state_next = powm_pkg::ST_DONE;
      powm_pkg::ST_DONE: state_next = powm_pkg::ST_IDLE;
      default: state_next = powm_pkg::ST_IDLE;
    endcase
  end

  // Oxygen ratio: ceil(25*R/I) as floor((25*R + I - 1) / I).
  assign div_num = (DW'(red_sum) << 4) + (DW'(red_sum) << 3) + DW'(red_sum)
                   + DW'(ir_sum) - DW'(1);
  assign div_den = DW'(ir_sum);

  // Mean: infrared sum times the scaled reciprocal of WINDOW, top chunk first.
  assign mul_chunk = RECIP_V[16*mul_k +: 16];
  assign mul_part = (SUMW+16)'(ir_sum) * (SUMW+16)'(mul_chunk);
  assign mean = SUMW'(acc >> SH);

  logic [PCW+7:0] hr_full;
  logic [13:0] hr_sat;
  assign hr_full = peaks * bpm_per_peak;
  assign hr_sat = (hr_full > (PCW+8)'(16383)) ? 14'd16383 : 14'(hr_full);

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      idx <= '0;
      head <= '0;
      out_valid <= 1'b0;
      div_phase <= 1'b0;
    end else begin
      if (clearing) begin
        idx <= idx + 1'b1;
        if (idx == (AW+1)'(WINDOW - 1)) begin
          clearing <= 1'b0;
          idx <= '0;
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        powm_pkg::ST_IDLE:
          if (in_valid && in_ready) begin
            red_hold <= red_in;
            ir_hold <= ir_in;
            idx <= '0;
            red_sum <= '0;
            ir_sum <= '0;
          end
        powm_pkg::ST_SHIFT: head <= wrap(head, (AW+1)'(1));
        powm_pkg::ST_SUM_RD: idx <= idx + 1'b1;
        powm_pkg::ST_SUM: begin
          red_sum <= red_sum + SUMW'(red_q);
          ir_sum <= ir_sum + SUMW'(ir_q);
          if (idx != (AW+1)'(WINDOW)) idx <= idx + 1'b1;
          else begin
            mul_k <= KW'(MCH - 1);
            acc <= '0;
          end
        end
        powm_pkg::ST_MEAN: begin
          acc <= (acc << 16) + PW'(mul_part);
          if (mul_k != '0) mul_k <= mul_k - 1'b1;
        end
        powm_pkg::ST_DIV: begin
          if (!div_phase) div_phase <= 1'b1;
          else if (!div_busy) begin
            div_phase <= 1'b0;
            if (ir_sum == '0 || div_q >= DW'(110)) spo2_r <= 7'd0;
            else if (div_q < DW'(10)) spo2_r <= 7'd100;
            else spo2_r <= 7'(DW'(110) - div_q);
            idx <= '0;
            peaks <= '0;
            have_last <= 1'b0;
            last <= '0;
          end
        end
        powm_pkg::ST_PEAK_RD: idx <= idx + 1'b1;
        powm_pkg::ST_PEAK: begin
          prev2 <= prev1;
          prev1 <= ir_q;
          // Entry idx-2 is the candidate once two reads are in.
          if (idx >= (AW+1)'(3) && peak_hit &&
              (!have_last || GW'(gap_d) > GW'(min_peak_gap))) begin
            peaks <= peaks + 1'b1;
            last <= idx - 2'd2;
            have_last <= 1'b1;
          end
          if (idx != (AW+1)'(WINDOW)) idx <= idx + 1'b1;
        end
        powm_pkg::ST_HR:
          if (hr_go) begin
            spo2_value <= spo2_r;
            average_ir <= (FW'(mean) > FW'(262143)) ? 18'h3FFFF : 18'(mean);
            if (FW'(mean) >= FW'(finger_level)) begin
              finger_present <= 1'b1;
              heart_rate <= hr_sat;
              alarm <= (spo2_r < spo2_floor) || (hr_sat < hr_min) || (hr_sat > hr_max);
            end else begin
              finger_present <= 1'b0;
              heart_rate <= '0;
              alarm <= 1'b0;
            end
          end
        powm_pkg::ST_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Checks on sequencing.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");
  assert property (@(posedge clk) disable iff (rst) clearing |-> !in_ready)
    else $error("input taken during clearing pass");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(spo2_value) && $stable(heart_rate))
    else $error("result dropped or changed while stalled");
endmodule
`default_nettype wire

// ----- test/pulse_oximetry_window_monitor_tb.sv -----
// Self-checking testbench for the pulse oximetry window monitor.
`default_nettype none
module pulse_oximetry_window_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 100;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int LONG_HOLD = 3000;
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_EVAL = 1'b1;
  localparam logic [2:0] CFG_PAST_LIST = 3'd6;
  localparam logic [2:0] CFG_LAST_CODE = 3'd7;

  typedef struct packed {
    logic [6:0]  spo2;
    logic [13:0] hr;
    logic [17:0] avg;
    logic        finger;
    logic        alarm;
  } vitals_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic req_type = 1'b0;
  logic [17:0] red_sample = '0, ir_sample = '0;
  logic out_valid, out_ready = 1'b0;
  logic [6:0] spo2_value;
  logic [13:0] heart_rate;
  logic [17:0] average_ir;
  logic finger_present, alarm;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pulse_oximetry_window_monitor DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the windows and the limit registers.
  logic [17:0] red_win [WIN];
  logic [17:0] ir_win [WIN];
  logic [6:0]  lim_spo2_floor;
  logic [13:0] lim_hr_min, lim_hr_max;
  logic [17:0] lim_finger;
  logic [7:0]  lim_gap, lim_bpm;

  vitals_t pending_vitals [$];
  int mismatches = 0;
  int results_seen = 0;
  int pushes_sent = 0;
  int evals_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  // Compute what an evaluate request reports for the current windows.
  function automatic vitals_t evaluate_window();
    vitals_t v;
    longint unsigned rsum, isum, mean, q, spo2, hr, peaks, last;
    bit have_last;
    rsum = 0;
    isum = 0;
    peaks = 0;
    last = 0;
    have_last = 1'b0;
    hr = 0;
    for (int i = 0; i < WIN; i++) begin
      rsum += red_win[i];
      isum += ir_win[i];
    end
    mean = isum / WIN;
    if (isum == 0) begin
      spo2 = 0;
    end else begin
      q = (25 * rsum + isum - 1) / isum;
      spo2 = (q >= 110) ? 0 : ((110 - q > 100) ? 100 : 110 - q);
    end
    v.finger = (mean >= lim_finger);
    v.alarm = 1'b0;
    if (v.finger) begin
      for (int i = 1; i < WIN - 1; i++) begin
        if (ir_win[i] > mean && ir_win[i] > ir_win[i-1] && ir_win[i] > ir_win[i+1]) begin
          if (!have_last || (longint'(i) - last) > lim_gap) begin
            peaks++;
            last = i;
            have_last = 1'b1;
          end
        end
      end
      hr = peaks * lim_bpm;
      if (hr > 16383) hr = 16383;
      v.alarm = (spo2 < lim_spo2_floor) || (hr < lim_hr_min) || (hr > lim_hr_max);
    end
    v.spo2 = spo2[6:0];
    v.hr = hr[13:0];
    v.avg = (mean > 262143) ? 18'h3FFFF : mean[17:0];
    return v;
  endfunction

  // Offer one request after a random gap (none when quiet) and update the shadow state on acceptance.
  task automatic send_request(input logic kind, input logic [17:0] red, input logic [17:0] ir);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    red_sample <= red;
    ir_sample <= ir;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if (kind == REQ_PUSH) begin
      for (int i = 0; i < WIN - 1; i++) begin
        red_win[i] = red_win[i+1];
        ir_win[i] = ir_win[i+1];
      end
      red_win[WIN-1] = red;
      ir_win[WIN-1] = ir;
      pushes_sent++;
    end else begin
      pending_vitals.push_back(evaluate_window());
      evals_sent++;
    end
  endtask

  // Wait for every outstanding result, then let a push in flight finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_vitals.size() == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One configuration transaction; the block must be idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_writes++;
    case (idx)
      powm_pkg::CFG_SPO2_FLOOR:   lim_spo2_floor = data[6:0];
      powm_pkg::CFG_HR_MIN:       lim_hr_min = data[13:0];
      powm_pkg::CFG_HR_MAX:       lim_hr_max = data[13:0];
      powm_pkg::CFG_FINGER_LEVEL: lim_finger = data[17:0];
      powm_pkg::CFG_MIN_PEAK_GAP: lim_gap = data[7:0];
      powm_pkg::CFG_BPM_PER_PEAK: lim_bpm = data[7:0];
      default: ;
    endcase
  endtask

  // Load all six limits, with random upper bits that the block must drop.
  task automatic set_limits(input int s, input int hmin, input int hmax, input int fl,
                            input int gap, input int bpm);
    wait_idle();
    write_reg(powm_pkg::CFG_SPO2_FLOOR,
              {$urandom_range(0, 1) ? $urandom() : 32'd0} & 32'hFFFF_FF80 | s);
    write_reg(powm_pkg::CFG_HR_MIN, ($urandom() & 32'hFFFF_C000) | hmin);
    write_reg(powm_pkg::CFG_HR_MAX, ($urandom() & 32'hFFFF_C000) | hmax);
    write_reg(powm_pkg::CFG_FINGER_LEVEL, ($urandom() & 32'hFFFC_0000) | fl);
    write_reg(powm_pkg::CFG_MIN_PEAK_GAP, ($urandom() & 32'hFFFF_FF00) | gap);
    write_reg(powm_pkg::CFG_BPM_PER_PEAK, ($urandom() & 32'hFFFF_FF00) | bpm);
    // Indexes past the register list must be ignored.
    write_reg(CFG_PAST_LIST, $urandom());
    write_reg(CFG_LAST_CODE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Directed: empty window, sample extremes, partial windows.
  task automatic test_directed();
    send_request(REQ_EVAL, 18'h3FFFF, 18'h3FFFF);
    send_request(REQ_PUSH, 18'h3FFFF, 18'h3FFFF);
    send_request(REQ_EVAL, '0, '0);
    send_request(REQ_PUSH, 18'h00000, 18'h3FFFF);
    send_request(REQ_PUSH, 18'h3FFFF, 18'h00000);
    send_request(REQ_EVAL, '0, '0);
    send_request(REQ_PUSH, 18'h2AAAA, 18'h15555);
    send_request(REQ_PUSH, 18'h15555, 18'h2AAAA);
    send_request(REQ_PUSH, 18'h00001, 18'h3FFFF);
    send_request(REQ_EVAL, '0, '0);
    // Zero infrared sum with nonzero red.
    set_limits(0, 0, 16383, 0, 0, 255);
    for (int i = 0; i < WIN; i++) send_request(REQ_PUSH, 18'h3FFFF, 18'h0);
    send_request(REQ_EVAL, '0, '0);
    // Single sharp peaks with no gap rule and finger always present.
    send_request(REQ_PUSH, 18'h100, 18'h3FFFF);
    send_request(REQ_PUSH, 18'h100, 18'h00010);
    send_request(REQ_PUSH, 18'h100, 18'h3FFF0);
    send_request(REQ_EVAL, '0, '0);
  endtask

  // Random phase: mostly pulse waveforms, some noise, some flat baseline, some evaluations.
  task automatic test_random(input int count);
    int period, base, amp, k;
    logic [17:0] red, ir;
    period = $urandom_range(2, 40);
    base = $urandom_range(0, 250000);
    amp = $urandom_range(0, 262143 - base);
    k = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(REQ_EVAL, 18'($urandom()), 18'($urandom()));
      end else begin
        if ($urandom_range(0, 49) == 0) begin
          period = $urandom_range(2, 40);
          base = $urandom_range(0, 250000);
          amp = $urandom_range(0, 262143 - base);
        end
        case ($urandom_range(0, 9))
          0: begin
            ir = 18'($urandom());
            red = 18'($urandom());
          end
          1: begin
            ir = 18'(base);
            red = 18'(base / 2);
          end
          default: begin
            ir = 18'(base + ((k % period == 0) ? amp : $urandom_range(0, amp / 8)));
            red = 18'((ir / 32) * $urandom_range(0, 40));
          end
        endcase
        k++;
        send_request(REQ_PUSH, red, ir);
      end
    end
  endtask

  // Block the receiver for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    quiet = 1'b1;
    test_random(80);
    quiet = 1'b0;
  endtask

  // Result sink: random ready stalls plus an optional long hold-off.
  always @(posedge clk) begin
    int s, h;
    cycles <= cycles + 1;
    s = stall_left;
    h = hold_left;
    if (hold_req) begin
      h = LONG_HOLD;
      hold_req = 1'b0;
    end else if (h > 0) begin
      h--;
    end
    if (out_valid && out_ready) begin
      vitals_t got, want;
      got = '{spo2_value, heart_rate, average_ir, finger_present, alarm};
      results_seen++;
      if (pending_vitals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_vitals.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: spo2 %0d/%0d hr %0d/%0d avg %0d/%0d finger %0b/%0b alarm %0b/%0b",
                     want.spo2, got.spo2, want.hr, got.hr, want.avg, got.avg,
                     want.finger, got.finger, want.alarm, got.alarm);
        end
      end
      s = quiet ? 0 : $urandom_range(0, 18);
    end else if (s > 0) begin
      s--;
    end
    stall_left <= s;
    hold_left <= h;
    out_ready <= (s == 0) && (h == 0);
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) begin
      red_win[i] = '0;
      ir_win[i] = '0;
    end
    lim_spo2_floor = 7'd90;
    lim_hr_min = 14'd40;
    lim_hr_max = 14'd130;
    lim_finger = 18'd10000;
    lim_gap = 8'd25;
    lim_bpm = 8'd60;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_limits(90, 40, 130, 10000, 25, 60);
    test_random(300);
    set_limits(100, 16383, 0, 0, 0, 255);
    test_random(300);
    set_limits(0, 0, 16383, 262143, 255, 0);
    test_random(250);
    test_backpressure();
    set_limits($urandom_range(0, 100), $urandom_range(0, 300), $urandom_range(0, 16383),
               $urandom_range(0, 200000), $urandom_range(0, 40), $urandom_range(0, 255));
    quiet = 1'b1;
    test_random(250);
    quiet = 1'b0;
    set_limits($urandom_range(0, 127), $urandom_range(0, 16383), $urandom_range(0, 16383),
               $urandom_range(0, 262143), $urandom_range(0, 255), $urandom_range(0, 255));
    test_random(400);
    wait_idle();
    $display("covered %0d pushes, %0d evaluations, %0d register writes", pushes_sent,
             evals_sent, cfg_writes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/powm_pkg.sv
design/powm_ram.sv
design/powm_divider.sv
design/pulse_oximetry_window_monitor.sv
test/pulse_oximetry_window_monitor_tb.sv
